FILE: rtl/core/had_pkg.sv
// shared types, constants and helpers for the humid air density pipeline
package had_pkg;

    typedef logic signed [41:0] t_acc;

    typedef struct packed {
        logic signed [20:0] t900;
        logic [27:0]        p16;
    } t_side;

    typedef struct packed {
        logic               v;
        t_acc               acc;
        logic signed [19:0] d900;
        t_side              side;
    } t_hrn;

    typedef struct packed {
        t_side      side;
        logic [1:0] flag;
    } t_tag;

    typedef struct packed {
        logic        v;
        logic [59:0] rem;
        logic [39:0] lo;
        logic [39:0] quo;
        logic [59:0] dvs;
        t_tag        tag;
    } t_div;

    // flag bits in the divider tag
    localparam int FLG_BIG = 0;
    localparam int FLG_LIM = 1;
    localparam int FLG_NEG = 0;
    localparam int FLG_OVF = 1;

    function automatic longint qc(input longint m);
        return (m * 64'sd268435456 + 64'sd500000000) / 64'sd1000000000;
    endfunction

    function automatic logic signed [20:0] deg900(input logic signed [15:0] h,
                                                  input logic imp);
        logic signed [20:0] w;
        w = 21'(h);
        return imp ? (w - 21'sd3200) * 21'sd5 : w * 21'sd9;
    endfunction

    // wobus coefficients for x = degC/100, q28
    localparam t_acc HRN_COEF [10] = '{
        t_acc'(qc(64'sd999996830)), t_acc'(-qc(64'sd908269510)),
        t_acc'(qc(64'sd787361690)), t_acc'(-qc(64'sd611179580)),
        t_acc'(qc(64'sd438841870)), t_acc'(-qc(64'sd298838850)),
        t_acc'(qc(64'sd218744250)), t_acc'(-qc(64'sd178923210)),
        t_acc'(qc(64'sd111120180)), t_acc'(-qc(64'sd30994571))
    };

    // reciprocal of 5625 for the divide by 90000 after a shift by 4
    localparam logic [127:0] HRN_M_FULL = ((128'd1 << 69) + 128'd5624) / 128'd5625;
    localparam logic [56:0]  HRN_M      = HRN_M_FULL[56:0];

    // inHg to 1/16 Pa: p*541 + (p*2427 + 1476) / 2953
    localparam logic [63:0] PRS_M_FULL = ((64'd1 << 42) + 64'd2952) / 64'd2953;
    localparam logic [30:0] PRS_M      = PRS_M_FULL[30:0];
    localparam logic [10:0] PRS_INT    = 11'd541;
    localparam logic [11:0] PRS_FRAC   = 12'd2427;
    localparam logic [10:0] PRS_HALF   = 11'd1476;

    localparam logic [63:0] PV_NUM_FULL = (64'd244312 * 64'd17592186044416 + 64'd12) / 64'd25;
    localparam logic [57:0] PV_NUM      = PV_NUM_FULL[57:0];
    localparam logic [30:0] PV_LIMIT    = 31'h4000_0000;

    localparam logic [63:0] K_DRY_FULL =
        (64'd10000 * 64'd1099511627776 + 64'd1435265) / 64'd2870531;
    localparam logic [63:0] K_VAP_FULL =
        (64'd10000 * 64'd1099511627776 + 64'd2307482) / 64'd4614964;
    localparam logic [63:0] K_MIX_FULL = K_DRY_FULL - K_VAP_FULL;
    localparam logic [31:0] K_DRY      = K_DRY_FULL[31:0];
    localparam logic [30:0] K_MIX      = K_MIX_FULL[30:0];

    localparam logic signed [20:0] ZERO_K900 = 21'sd245835;
    localparam logic [21:0]        OUT_SCALE = 22'd3515625;
    localparam logic [23:0]        OUT_MAX   = 24'hFF_FFFF;

endpackage

FILE: rtl/core/humid_air_density_top.sv
// humid air density pipeline: unit conversion, wobus vapor pressure, density
// Takes one sample per clock while o_stall is low and returns one result per
// sample, in order. The chain holds 9 horner cells of 5 stages, a 31-cell
// divider for the vapor pressure, a 40-cell divider by the absolute temperature,
// and the conversion, power and scaling stages around them. An output register
// and one skid entry decouple o_stall from i_stall, so the input keeps flowing
// while a result waits. i_cfg_wdata selects imperial units (F, inHg); the user
// must write it only while no sample is in flight; the block does not enforce it.
module humid_air_density_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_air_temperature,
    input  logic [17:0]        i_air_pressure,
    input  logic signed [15:0] i_dew_point,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [23:0]        o_density_micro,
    output logic               o_out_of_range
);
    import had_pkg::*;

    localparam int HRN_CELLS  = 9;
    localparam int DIVA_STEPS = 31;
    localparam int DIVB_STEPS = 40;

    typedef struct packed {
        logic               v;
        logic               imp;
        logic signed [20:0] t900;
        logic signed [19:0] d900;
        logic [17:0]        praw;
        logic [27:0]        base;
        logic [29:0]        n2;
    } t_s0;

    typedef struct packed {
        logic               v;
        logic               imp;
        logic signed [20:0] t900;
        logic signed [19:0] d900;
        logic [17:0]        praw;
        logic [27:0]        base;
        logic [60:0]        prod;
    } t_s1;

    typedef struct packed {
        logic        v;
        logic        big;
        logic [31:0] s2;
        t_side       side;
    } t_v1;

    typedef struct packed {
        logic        v;
        logic        big;
        logic [29:0] s4;
        t_side       side;
    } t_v2;

    typedef struct packed {
        logic        v;
        logic        big;
        logic [59:0] s8;
        t_side       side;
    } t_v3;

    typedef struct packed {
        logic        v;
        logic [30:0] pv;
        t_side       side;
    } t_v5;

    typedef struct packed {
        logic               v;
        logic [59:0]        pd;
        logic [61:0]        pvv;
        logic signed [20:0] t900;
    } t_u1;

    typedef struct packed {
        logic        v;
        logic        neg;
        logic [59:0] u;
        logic [19:0] t900;
    } t_u2;

    typedef struct packed {
        logic        v;
        logic        neg;
        logic        ovf;
        logic [41:0] ph;
        logic [41:0] pl;
    } t_r1;

    typedef struct packed {
        logic        v;
        logic [23:0] dens;
        logic        oor;
    } t_fin;

    logic  r_imp;
    logic  w_en;

    t_s0   r_s0, n_s0;
    t_s1   r_s1, n_s1;
    t_hrn  r_h0, n_h0;
    t_v1   r_v1, n_v1;
    t_v2   r_v2, n_v2;
    t_v3   r_v3, n_v3;
    t_div  r_v4, n_v4;
    t_v5   r_v5, n_v5;
    t_u1   r_u1, n_u1;
    t_u2   r_u2, n_u2;
    t_div  r_u3, n_u3;
    t_r1   r_r1, n_r1;
    t_fin  r_fin, n_fin;

    logic        r_out_v;
    logic [23:0] r_out_dens;
    logic        r_out_oor;
    logic        r_skid_v;
    logic [23:0] r_skid_dens;
    logic        r_skid_oor;

    t_hrn  w_hrn [HRN_CELLS+1];
    t_div  w_dva [DIVA_STEPS+1];
    t_div  w_dvb [DIVB_STEPS+1];

    logic [41:0]  w_mag;
    logic [59:0]  w_sq2;
    logic [63:0]  w_sq4;
    logic [59:0]  w_nn;
    logic [62:0]  w_u;
    logic [61:0]  w_sum;
    logic [25:0]  w_r;

    // whole pipeline moves unless the skid entry is occupied
    assign w_en    = !r_skid_v;
    assign o_stall = r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_imp <= 1'b0;
        end else if (i_cfg_we) begin
            r_imp <= i_cfg_wdata;
        end
    end

    // unit conversion
    always_comb begin
        n_s0.v    = i_valid && !o_stall;
        n_s0.imp  = r_imp;
        n_s0.t900 = deg900(i_air_temperature, r_imp) + ZERO_K900;
        n_s0.d900 = 20'(deg900(i_dew_point, r_imp));
        n_s0.praw = i_air_pressure;
        n_s0.base = 28'(i_air_pressure) * 28'(PRS_INT);
        n_s0.n2   = 30'(i_air_pressure) * 30'(PRS_FRAC) + 30'(PRS_HALF);
    end

    always_comb begin
        n_s1.v    = r_s0.v;
        n_s1.imp  = r_s0.imp;
        n_s1.t900 = r_s0.t900;
        n_s1.d900 = r_s0.d900;
        n_s1.praw = r_s0.praw;
        n_s1.base = r_s0.base;
        n_s1.prod = 61'(r_s0.n2) * 61'(PRS_M);
    end

    always_comb begin
        n_h0.v         = r_s1.v;
        n_h0.acc       = HRN_COEF[9];
        n_h0.d900      = r_s1.d900;
        n_h0.side.t900 = r_s1.t900;
        n_h0.side.p16  = r_s1.imp ? r_s1.base + 28'(r_s1.prod[60:42])
                                  : 28'({r_s1.praw, 4'd0});
    end

    assign w_hrn[0] = r_h0;

    for (genvar g = 0; g < HRN_CELLS; g++) begin : g_hrn
        had_horner_cell u_hrn (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_coef  (HRN_COEF[HRN_CELLS-1-g]),
            .i_data  (w_hrn[g]),
            .o_data  (w_hrn[g+1])
        );
    end

    // eighth power of the polynomial
    always_comb begin
        w_mag = w_hrn[HRN_CELLS].acc[41] ? 42'(-w_hrn[HRN_CELLS].acc)
                                         : 42'(w_hrn[HRN_CELLS].acc);
        w_sq2     = 60'(w_mag[29:0]) * 60'(w_mag[29:0]);
        n_v1.v    = w_hrn[HRN_CELLS].v;
        n_v1.big  = |w_mag[41:30];
        n_v1.s2   = w_sq2[59:28];
        n_v1.side = w_hrn[HRN_CELLS].side;
    end

    always_comb begin
        w_sq4     = 64'(r_v1.s2) * 64'(r_v1.s2);
        n_v2.v    = r_v1.v;
        n_v2.big  = r_v1.big;
        n_v2.s4   = w_sq4[63:34];
        n_v2.side = r_v1.side;
    end

    always_comb begin
        n_v3.v    = r_v2.v;
        n_v3.big  = r_v2.big;
        n_v3.s8   = 60'(r_v2.s4) * 60'(r_v2.s4);
        n_v3.side = r_v2.side;
    end

    // rounded vapor pressure quotient setup
    always_comb begin
        w_nn               = 60'(PV_NUM) + {1'b0, r_v3.s8[59:1]};
        n_v4.v             = r_v3.v;
        n_v4.rem           = 60'(w_nn[59:31]);
        n_v4.lo            = {w_nn[30:0], 9'd0};
        n_v4.quo           = '0;
        n_v4.dvs           = r_v3.s8;
        n_v4.tag.side      = r_v3.side;
        n_v4.tag.flag      = '0;
        n_v4.tag.flag[FLG_BIG] = r_v3.big;
        n_v4.tag.flag[FLG_LIM] = (r_v3.s8 == '0) || (60'(w_nn[59:31]) >= r_v3.s8);
    end

    assign w_dva[0] = r_v4;

    for (genvar g = 0; g < DIVA_STEPS; g++) begin : g_dva
        had_div_cell u_dva (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_data  (w_dva[g]),
            .o_data  (w_dva[g+1])
        );
    end

    always_comb begin
        n_v5.v    = w_dva[DIVA_STEPS].v;
        n_v5.side = w_dva[DIVA_STEPS].tag.side;
        if (w_dva[DIVA_STEPS].tag.flag[FLG_BIG]) begin
            n_v5.pv = '0;
        end else if (w_dva[DIVA_STEPS].tag.flag[FLG_LIM]
                     || w_dva[DIVA_STEPS].quo[30:0] > PV_LIMIT) begin
            n_v5.pv = PV_LIMIT;
        end else begin
            n_v5.pv = w_dva[DIVA_STEPS].quo[30:0];
        end
    end

    // dry and vapor partial densities
    always_comb begin
        n_u1.v    = r_v5.v;
        n_u1.pd   = 60'(r_v5.side.p16) * 60'(K_DRY);
        n_u1.pvv  = 62'(r_v5.pv) * 62'(K_MIX);
        n_u1.t900 = r_v5.side.t900;
    end

    always_comb begin
        w_u       = 63'(r_u1.pd) - 63'(r_u1.pvv);
        n_u2.v    = r_u1.v;
        n_u2.neg  = w_u[62] || r_u1.t900[20] || (r_u1.t900 == '0);
        n_u2.u    = w_u[59:0];
        n_u2.t900 = r_u1.t900[19:0];
    end

    always_comb begin
        n_u3.v             = r_u2.v;
        n_u3.rem           = 60'(r_u2.u[59:40]);
        n_u3.lo            = r_u2.u[39:0];
        n_u3.quo           = '0;
        n_u3.dvs           = 60'(r_u2.t900);
        n_u3.tag.side      = '0;
        n_u3.tag.flag      = '0;
        n_u3.tag.flag[FLG_NEG] = r_u2.neg;
        n_u3.tag.flag[FLG_OVF] = r_u2.u[59:40] >= r_u2.t900;
    end

    assign w_dvb[0] = r_u3;

    for (genvar g = 0; g < DIVB_STEPS; g++) begin : g_dvb
        had_div_cell u_dvb (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_data  (w_dvb[g]),
            .o_data  (w_dvb[g+1])
        );
    end

    // scale to micro kg per cubic metre
    always_comb begin
        n_r1.v   = w_dvb[DIVB_STEPS].v;
        n_r1.neg = w_dvb[DIVB_STEPS].tag.flag[FLG_NEG];
        n_r1.ovf = w_dvb[DIVB_STEPS].tag.flag[FLG_OVF];
        n_r1.ph  = 42'(w_dvb[DIVB_STEPS].quo[39:20]) * 42'(OUT_SCALE);
        n_r1.pl  = 42'(w_dvb[DIVB_STEPS].quo[19:0]) * 42'(OUT_SCALE);
    end

    always_comb begin
        w_sum   = {r_r1.ph, 20'd0} + 62'(r_r1.pl) + (62'd1 << 35);
        w_r     = w_sum[61:36];
        n_fin.v = r_r1.v;
        if (r_r1.neg) begin
            n_fin.dens = '0;
            n_fin.oor  = 1'b1;
        end else if (r_r1.ovf || (|w_r[25:24])) begin
            n_fin.dens = OUT_MAX;
            n_fin.oor  = 1'b1;
        end else begin
            n_fin.dens = w_r[23:0];
            n_fin.oor  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.v  <= 1'b0;
            r_s1.v  <= 1'b0;
            r_h0.v  <= 1'b0;
            r_v1.v  <= 1'b0;
            r_v2.v  <= 1'b0;
            r_v3.v  <= 1'b0;
            r_v4.v  <= 1'b0;
            r_v5.v  <= 1'b0;
            r_u1.v  <= 1'b0;
            r_u2.v  <= 1'b0;
            r_u3.v  <= 1'b0;
            r_r1.v  <= 1'b0;
            r_fin.v <= 1'b0;
        end else if (w_en) begin
            r_s0  <= n_s0;
            r_s1  <= n_s1;
            r_h0  <= n_h0;
            r_v1  <= n_v1;
            r_v2  <= n_v2;
            r_v3  <= n_v3;
            r_v4  <= n_v4;
            r_v5  <= n_v5;
            r_u1  <= n_u1;
            r_u2  <= n_u2;
            r_u3  <= n_u3;
            r_r1  <= n_r1;
            r_fin <= n_fin;
        end
    end

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (r_out_v && !i_stall) begin
                r_out_dens <= r_skid_dens;
                r_out_oor  <= r_skid_oor;
                r_skid_v   <= 1'b0;
            end
        end else if (r_fin.v) begin
            if (!r_out_v || !i_stall) begin
                r_out_v    <= 1'b1;
                r_out_dens <= r_fin.dens;
                r_out_oor  <= r_fin.oor;
            end else begin
                r_skid_v    <= 1'b1;
                r_skid_dens <= r_fin.dens;
                r_skid_oor  <= r_fin.oor;
            end
        end else if (r_out_v && !i_stall) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_valid         = r_out_v;
    assign o_density_micro = r_out_dens;
    assign o_out_of_range  = r_out_oor;

endmodule

FILE: rtl/core/had_horner_cell.sv
// one horner step of the dewpoint polynomial, five register stages
module had_horner_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  had_pkg::t_acc  i_coef,
    input  had_pkg::t_hrn  i_data,
    output had_pkg::t_hrn  o_data
);
    import had_pkg::*;

    typedef struct packed {
        logic               v;
        logic               neg;
        logic [40:0]        pa;
        logic [38:0]        pb;
        logic signed [19:0] d900;
        t_side              side;
    } t_h1;

    typedef struct packed {
        logic               v;
        logic               neg;
        logic [27:0]        nh;
        logic [27:0]        nl;
        logic signed [19:0] d900;
        t_side              side;
    } t_h2;

    typedef struct packed {
        logic               v;
        logic               neg;
        logic [56:0]        hh;
        logic [55:0]        hl;
        logic [56:0]        lh;
        logic [55:0]        ll;
        logic signed [19:0] d900;
        t_side              side;
    } t_h3;

    typedef struct packed {
        logic               v;
        logic               neg;
        logic [56:0]        hh;
        logic [57:0]        mid;
        logic [55:0]        ll;
        logic signed [19:0] d900;
        t_side              side;
    } t_h4;

    t_h1  r_h1, n_h1;
    t_h2  r_h2, n_h2;
    t_h3  r_h3, n_h3;
    t_h4  r_h4, n_h4;
    t_hrn r_h5, n_h5;

    logic [41:0]  w_mag_a;
    logic [18:0]  w_mag_d;
    logic [60:0]  w_n;
    logic [112:0] w_full;
    logic [41:0]  w_q;

    // magnitude product split in two halves
    always_comb begin
        w_mag_a = i_data.acc[41] ? 42'(-i_data.acc) : 42'(i_data.acc);
        w_mag_d = i_data.d900[19] ? 19'(-i_data.d900) : 19'(i_data.d900);
        n_h1.v    = i_data.v;
        n_h1.neg  = i_data.acc[41] ^ i_data.d900[19];
        n_h1.pa   = 41'(w_mag_a[41:20]) * 41'(w_mag_d);
        n_h1.pb   = 39'(w_mag_a[19:0]) * 39'(w_mag_d);
        n_h1.d900 = i_data.d900;
        n_h1.side = i_data.side;
    end

    // join halves and drop the factor of 16
    always_comb begin
        w_n       = {r_h1.pa, 20'd0} + 61'(r_h1.pb);
        n_h2.v    = r_h1.v;
        n_h2.neg  = r_h1.neg;
        n_h2.nh   = w_n[59:32];
        n_h2.nl   = w_n[31:4];
        n_h2.d900 = r_h1.d900;
        n_h2.side = r_h1.side;
    end

    // partial products with the reciprocal of 5625
    always_comb begin
        n_h3.v    = r_h2.v;
        n_h3.neg  = r_h2.neg;
        n_h3.hh   = 57'(r_h2.nh) * 57'(HRN_M[56:28]);
        n_h3.hl   = 56'(r_h2.nh) * 56'(HRN_M[27:0]);
        n_h3.lh   = 57'(r_h2.nl) * 57'(HRN_M[56:28]);
        n_h3.ll   = 56'(r_h2.nl) * 56'(HRN_M[27:0]);
        n_h3.d900 = r_h2.d900;
        n_h3.side = r_h2.side;
    end

    always_comb begin
        n_h4.v    = r_h3.v;
        n_h4.neg  = r_h3.neg;
        n_h4.hh   = r_h3.hh;
        n_h4.mid  = 58'(r_h3.hl) + 58'(r_h3.lh);
        n_h4.ll   = r_h3.ll;
        n_h4.d900 = r_h3.d900;
        n_h4.side = r_h3.side;
    end

    // quotient, sign and coefficient
    always_comb begin
        w_full    = {r_h4.hh, 56'd0} + 113'({r_h4.mid, 28'd0}) + 113'(r_h4.ll);
        w_q       = w_full[110:69];
        n_h5.v    = r_h4.v;
        n_h5.acc  = i_coef + (r_h4.neg ? -$signed(w_q) : $signed(w_q));
        n_h5.d900 = r_h4.d900;
        n_h5.side = r_h4.side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h1.v <= 1'b0;
            r_h2.v <= 1'b0;
            r_h3.v <= 1'b0;
            r_h4.v <= 1'b0;
            r_h5.v <= 1'b0;
        end else if (i_en) begin
            r_h1 <= n_h1;
            r_h2 <= n_h2;
            r_h3 <= n_h3;
            r_h4 <= n_h4;
            r_h5 <= n_h5;
        end
    end

    assign o_data = r_h5;

endmodule

FILE: rtl/core/had_div_cell.sv
// one restoring division step, one quotient bit per cell
module had_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  had_pkg::t_div i_data,
    output had_pkg::t_div o_data
);
    import had_pkg::*;

    t_div        r_d, n_d;
    logic [60:0] w_trial;
    logic        w_ge;

    always_comb begin
        w_trial  = {i_data.rem, i_data.lo[39]};
        w_ge     = w_trial >= {1'b0, i_data.dvs};
        n_d.v    = i_data.v;
        n_d.rem  = w_ge ? 60'(w_trial - {1'b0, i_data.dvs}) : w_trial[59:0];
        n_d.lo   = {i_data.lo[38:0], 1'b0};
        n_d.quo  = {i_data.quo[38:0], w_ge};
        n_d.dvs  = i_data.dvs;
        n_d.tag  = i_data.tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.v <= 1'b0;
        end else if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_data = r_d;

endmodule

FILE: sim/tb_top.sv
// self-checking testbench for the humid air density pipeline
`timescale 1ns / 1ps

module tb_top;
    import had_pkg::*;

    typedef struct {
        logic               imp;
        logic signed [15:0] temp;
        logic [17:0]        pres;
        logic signed [15:0] dew;
        bit                 known;
        logic [23:0]        dens;
        logic               oor;
    } t_row;

    typedef struct {
        logic [23:0] dens;
        logic        oor;
    } t_density;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_wdata = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [15:0] i_air_temperature = '0;
    logic [17:0]        i_air_pressure = '0;
    logic signed [15:0] i_dew_point = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [23:0]        o_density_micro;
    logic               o_out_of_range;

    t_density   density_due[$];
    logic       units_imp = 1'b0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         n_sent = 0;
    int         n_got = 0;
    int         n_bad = 0;
    int         quiet_cycles = 0;
    longint     wobus_coef [10];
    t_row       directed [$];

    humid_air_density_top DUT (.*);

    always #5 i_clk = ~i_clk;

    function automatic longint coef_q28(input longint m);
        return (m * 268435456 + 500000000) / 1000000000;
    endfunction

    function automatic longint to_deg900(input logic signed [15:0] h, input logic imp);
        longint v;
        v = h;
        return imp ? (v - 3200) * 5 : v * 9;
    endfunction

    function automatic longint unsigned vapor_pressure16(input longint d900);
        longint acc;
        longint unsigned q, s2, s4, s8, v;
        acc = wobus_coef[9];
        for (int k = 8; k >= 0; k--) acc = wobus_coef[k] + (acc * d900) / 90000;
        q = acc < 0 ? longint'(-acc) : acc;
        if (q >= (64'd1 << 30)) return 0;
        s2 = (q * q) >> 28;
        s4 = (s2 * s2) >> 28;
        s4 = s4 >> 6;
        s8 = s4 * s4;
        if (s8 == 0) return 64'd1 << 30;
        v = ((64'd244312 * 64'd17592186044416 + 64'd12) / 64'd25 + s8 / 2) / s8;
        return v > (64'd1 << 30) ? (64'd1 << 30) : v;
    endfunction

    function automatic t_density predict_density(input logic imp, input logic signed [15:0] temp,
                                                 input logic [17:0] pres,
                                                 input logic signed [15:0] dew);
        t_density r;
        longint t900, u, k_dry, k_mix;
        longint unsigned p16, pv16, y, s;
        k_dry = (10000 * 64'd1099511627776 + 1435265) / 2870531;
        k_mix = k_dry - (10000 * 64'd1099511627776 + 2307482) / 4614964;
        r.dens = '0;
        r.oor = 1'b0;
        t900 = to_deg900(temp, imp) + 245835;
        if (t900 <= 0) begin
            r.oor = 1'b1;
            return r;
        end
        p16 = imp ? (longint'(pres) * 1600000 + 1476) / 2953 : longint'(pres) * 16;
        pv16 = vapor_pressure16(to_deg900(dew, imp));
        u = longint'(p16) * k_dry - longint'(pv16) * k_mix;
        if (u < 0) begin
            r.oor = 1'b1;
            return r;
        end
        y = longint'(u) / t900;
        s = (y * 3515625 + (64'd1 << 35)) >> 36;
        if (y >= (64'd1 << 40) || s > 64'hFF_FFFF) begin
            r.dens = OUT_MAX;
            r.oor = 1'b1;
        end else begin
            r.dens = s[23:0];
        end
        return r;
    endfunction

    task automatic send_sample(input logic signed [15:0] temp, input logic [17:0] pres,
                               input logic signed [15:0] dew);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_air_temperature <= temp;
        i_air_pressure <= pres;
        i_dew_point <= dew;
        do @(posedge i_clk); while (o_stall);
        density_due.push_back(predict_density(units_imp, temp, pres, dew));
        n_sent++;
    endtask

    task automatic set_units(input logic imp);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (density_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= imp;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        units_imp = imp;
    endtask

    task automatic random_phase(input logic imp, input int s_pct, input int r_pct, input int n);
        logic signed [15:0] t, d;
        logic [17:0]        p;
        set_units(imp);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (n) begin
            if ($urandom_range(99) < 75) begin
                t = imp ? 16'($urandom_range(14000) - 4000)
                        : 16'($urandom_range(9000) - 4000);
                d = 16'(t - 16'($urandom_range(3000)));
                p = imp ? 18'($urandom_range(3300, 2500)) : 18'($urandom_range(110000, 70000));
            end else begin
                t = 16'($urandom_range(40000) - 20000);
                d = 16'($urandom_range(40000) - 20000);
                p = 18'($urandom_range(200000));
            end
            send_sample(t, p, d);
        end
    endtask

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
        if (i_rst_n && o_valid && !i_stall) begin
            n_got++;
            if (density_due.size() == 0) begin
                $display("%0t: unexpected result density %0d flag %0b", $time,
                         o_density_micro, o_out_of_range);
                n_bad++;
            end else begin
                t_density e;
                e = density_due.pop_front();
                if (e.dens !== o_density_micro || e.oor !== o_out_of_range) begin
                    $display("%0t: mismatch expected density %0d flag %0b, actual %0d flag %0b",
                             $time, e.dens, e.oor, o_density_micro, o_out_of_range);
                    n_bad++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 20000) begin
            $display("%0t: watchdog expired", $time);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        longint mags [10] = '{999996830, 908269510, 787361690, 611179580, 438841870,
                              298838850, 218744250, 178923210, 111120180, 30994571};
        for (int k = 0; k < 10; k++)
            wobus_coef[k] = (k % 2) ? -coef_q28(mags[k]) : coef_q28(mags[k]);

        // absolute zero and below, zero pressure, full-scale saturation
        directed.push_back('{1'b0, -16'sd27315, 18'd101325, 16'sd0, 1, 24'd0, 1'b1});
        directed.push_back('{1'b0, -16'sd32768, 18'd200000, 16'sd0, 1, 24'd0, 1'b1});
        directed.push_back('{1'b0, 16'sd1500, 18'd0, 16'sd0, 1, 24'd0, 1'b1});
        directed.push_back('{1'b0, 16'sd1500, 18'd101325, 16'sd1000, 0, 0, 0});
        directed.push_back('{1'b0, -16'sd20000, 18'd200000, -16'sd20000, 0, 0, 0});
        directed.push_back('{1'b0, 16'sd20000, 18'd200000, 16'sd20000, 0, 0, 0});
        directed.push_back('{1'b0, 16'sd20000, 18'd0, 16'sd20000, 0, 0, 0});
        directed.push_back('{1'b0, 16'sd20000, 18'd0, -16'sd20000, 0, 0, 0});
        directed.push_back('{1'b0, -16'sd20000, 18'd1, 16'sd32767, 0, 0, 0});
        directed.push_back('{1'b0, 16'sd0, 18'd262143, -16'sd32768, 0, 0, 0});
        directed.push_back('{1'b0, 16'sd3000, 18'd100000, 16'sd12000, 0, 0, 0});
        directed.push_back('{1'b1, -16'sd20000, 18'd200000, -16'sd20000, 1, OUT_MAX, 1'b1});
        directed.push_back('{1'b1, 16'sd7000, 18'd2992, 16'sd5000, 0, 0, 0});
        directed.push_back('{1'b1, 16'sd20000, 18'd0, 16'sd20000, 0, 0, 0});
        directed.push_back('{1'b1, 16'sd20000, 18'd200000, 16'sd20000, 0, 0, 0});
        directed.push_back('{1'b1, -16'sd20000, 18'd0, -16'sd20000, 0, 0, 0});
        directed.push_back('{1'b1, 16'sd3200, 18'd2953, 16'sd3200, 0, 0, 0});
        directed.push_back('{1'b1, 16'sd0, 18'd262143, 16'sd32767, 0, 0, 0});

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_units(1'b0);
        foreach (directed[n]) begin
            if (directed[n].imp !== units_imp) set_units(directed[n].imp);
            send_sample(directed[n].temp, directed[n].pres, directed[n].dew);
            if (directed[n].known) begin
                t_density typed;
                typed.dens = directed[n].dens;
                typed.oor = directed[n].oor;
                if (typed.dens !== density_due[$].dens || typed.oor !== density_due[$].oor) begin
                    $display("%0t: row %0d expected density %0d flag %0b, model %0d flag %0b",
                             $time, n, typed.dens, typed.oor, density_due[$].dens,
                             density_due[$].oor);
                    n_bad++;
                end
            end
        end

        random_phase(1'b0, 24, 62, 275);
        random_phase(1'b1, 24, 62, 275);
        random_phase(1'b0, 62, 24, 275);
        random_phase(1'b1, 62, 24, 275);
        random_phase(1'b0, 0, 0, 275);
        random_phase(1'b1, 0, 0, 275);

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (density_due.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("sent %0d samples in both unit modes under three stall patterns", n_sent);
        $display("checked %0d results, %0d mismatches", n_got, n_bad);
        if (n_bad == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/had_pkg.sv
rtl/core/had_horner_cell.sv
rtl/core/had_div_cell.sv
rtl/core/humid_air_density_top.sv
sim/tb_top.sv
